// File: design/bgsc_pkg.sv
// ---------------------------------------------------------------------------
// bgsc_pkg
// shared types, register indexes and reset values for the button gesture
// scroll control block
// ---------------------------------------------------------------------------
`default_nettype none

package bgsc_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned MsW     = 16;
  localparam int unsigned StepW   = 3;
  localparam int unsigned OffW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD         = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DOUBLE_CLICK = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SCROLL_PER   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BASE_STEP    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MIN_OFFSET   = 3'd5;

  localparam logic [MsW-1:0]   RST_LONG_PRESS   = 16'd1000;
  localparam logic [MsW-1:0]   RST_HOLD         = 16'd400;
  localparam logic [MsW-1:0]   RST_DOUBLE_CLICK = 16'd300;
  localparam logic [MsW-1:0]   RST_SCROLL_PER   = 16'd80;
  localparam logic [StepW-1:0] RST_BASE_STEP    = 3'd3;

  typedef enum logic [1:0] {
    MODE_DOWN   = 2'd0,
    MODE_TOP    = 2'd1,
    MODE_UP     = 2'd2,
    MODE_BOTTOM = 2'd3
  } mode_t;

  typedef struct packed {
    logic [MsW-1:0]          long_press_ms;
    logic [MsW-1:0]          hold_ms;
    logic [MsW-1:0]          double_click_ms;
    logic [MsW-1:0]          scroll_period_ms;
    logic [StepW-1:0]        base_step;
    logic signed [OffW-1:0]  min_offset;
  } cfg_t;

  typedef struct packed {
    logic                    exit_request;
    logic                    redraw;
    logic signed [OffW-1:0]  scroll_offset;
    mode_t                   scroll_mode;
  } res_t;

  typedef struct packed {
    logic                    prev_level;
    logic [TimeW-1:0]        press_time;
    logic [TimeW-1:0]        release_time;
    logic [TimeW-1:0]        scroll_time;
    logic                    holding;
    logic                    second_click_wait;
    logic                    single_click_pending;
    logic                    drain;
    mode_t                   mode;
    logic signed [OffW-1:0]  offset;
  } state_t;

endpackage

`default_nettype wire

// File: design/bgsc_if.sv
// ---------------------------------------------------------------------------
// bgsc channel interfaces
// valid/ready channels for button samples and scroll results
// ---------------------------------------------------------------------------
`default_nettype none

interface bgsc_in_if
  import bgsc_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic             button_level;
  logic [TimeW-1:0] now_ms;

  modport source (output valid, output button_level, output now_ms, input ready);
  modport sink   (input valid, input button_level, input now_ms, output ready);
endinterface

interface bgsc_out_if
  import bgsc_pkg::*;
  ;
  logic                   valid;
  logic                   ready;
  logic                   exit_request;
  logic                   redraw;
  logic signed [OffW-1:0] scroll_offset;
  logic [1:0]             scroll_mode;

  modport source (output valid, output exit_request, output redraw,
                  output scroll_offset, output scroll_mode, input ready);
  modport sink   (input valid, input exit_request, input redraw,
                  input scroll_offset, input scroll_mode, output ready);
endinterface

`default_nettype wire

// File: design/button_gesture_scroll_control_unit.sv
// ---------------------------------------------------------------------------
// button_gesture_scroll_control_unit
// button gesture detector driving a clamped scroll offset and mode
//
// samples carries one button level and a millisecond timestamp per item;
// results returns exactly one item per sample: exit_request, redraw,
// scroll_offset and scroll_mode after that sample.
// a sample goes into an input register, is evaluated against the gesture
// state by combinational logic and lands in the result register, which
// drives results.valid; a receiver stall can delay the move between them.
// one sample per cycle is taken sustained while results.ready stays high;
// the gesture state update is combinational compare and add logic.
// when the receiver stalls, the result register holds and the input
// register fills; samples.ready drops only when both are occupied.
// configuration is written through cfg_we / cfg_index / cfg_wdata while
// the block is idle; unknown indexes are ignored.
// reset clears both stages, loads the register reset values and puts the
// view at offset 0 in the stopped-at-top mode.
// ---------------------------------------------------------------------------
`default_nettype none

module button_gesture_scroll_control_unit
  import bgsc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgW-1:0]    cfg_wdata,
  bgsc_in_if.sink                 samples,
  bgsc_out_if.source              results
);

  cfg_t             cfg;
  res_t             res;
  res_t             out_res;
  logic             out_valid;
  logic             s1_valid;
  logic             s1_level;
  logic [TimeW-1:0] s1_now;
  logic             adv;
  logic             take;

  bgsc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bgsc_gesture u_gesture (
    .clk   (clk),
    .rst   (rst),
    .fire  (adv),
    .level (s1_level),
    .now   (s1_now),
    .cfg   (cfg),
    .res   (res)
  );

  assign adv           = s1_valid && (!out_valid || results.ready);
  assign samples.ready = !s1_valid || adv;
  assign take          = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_level <= samples.button_level;
      s1_now   <= samples.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

  assign results.valid         = out_valid;
  assign results.exit_request  = out_res.exit_request;
  assign results.redraw        = out_res.redraw;
  assign results.scroll_offset = out_res.scroll_offset;
  assign results.scroll_mode   = out_res.scroll_mode;

endmodule

`default_nettype wire

// File: design/bgsc_cfg.sv
// ---------------------------------------------------------------------------
// bgsc_cfg
// configuration register file, written through a plain write port
// ---------------------------------------------------------------------------
`default_nettype none

module bgsc_cfg
  import bgsc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgW-1:0]    cfg_wdata,
  output cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ms    <= RST_LONG_PRESS;
      cfg.hold_ms          <= RST_HOLD;
      cfg.double_click_ms  <= RST_DOUBLE_CLICK;
      cfg.scroll_period_ms <= RST_SCROLL_PER;
      cfg.base_step        <= RST_BASE_STEP;
      cfg.min_offset       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LONG_PRESS:   cfg.long_press_ms    <= cfg_wdata;
        CFG_HOLD:         cfg.hold_ms          <= cfg_wdata;
        CFG_DOUBLE_CLICK: cfg.double_click_ms  <= cfg_wdata;
        CFG_SCROLL_PER:   cfg.scroll_period_ms <= cfg_wdata;
        CFG_BASE_STEP:    cfg.base_step        <= cfg_wdata[StepW-1:0];
        CFG_MIN_OFFSET:   cfg.min_offset       <= signed'(cfg_wdata[OffW-1:0]);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/bgsc_gesture.sv
// ---------------------------------------------------------------------------
// bgsc_gesture
// gesture state registers and the per-sample update: click, double click,
// hold and long press detection, mode stepping and clamped scrolling
// ---------------------------------------------------------------------------
`default_nettype none

module bgsc_gesture
  import bgsc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire logic             level,
  input  wire logic [TimeW-1:0] now,
  input  cfg_t                  cfg,
  output res_t                  res
);

  state_t st;
  state_t st_next;

  always_comb begin
    logic                   eff_prev;
    logic                   done;
    logic [TimeW-1:0]       held;
    logic [TimeW-1:0]       since_rel;
    logic [TimeW-1:0]       since_scroll;
    logic [3:0]             step;
    logic signed [OffW:0]   off;

    st_next           = st;
    res.exit_request  = 1'b0;
    res.redraw        = 1'b0;
    res.scroll_offset = st.offset;
    res.scroll_mode   = st.mode;
    done              = 1'b0;
    eff_prev          = st.prev_level;
    held              = now - st.press_time;
    since_rel         = '0;
    since_scroll      = now - st.scroll_time;
    step              = '0;
    off               = '0;

    // drain after a long press exit
    if (st.drain) begin
      if (!level) begin
        done = 1'b1;
      end else begin
        st_next.drain = 1'b0;
        eff_prev      = 1'b1;
      end
    end

    if (!done && !level && eff_prev) begin
      st_next.press_time = now;
      st_next.holding    = 1'b0;
    end

    if (!done && !level && !eff_prev) begin
      if ((held > TimeW'(cfg.long_press_ms)) &&
          ((st.mode == MODE_TOP) || (st.mode == MODE_BOTTOM))) begin
        st_next.drain                = 1'b1;
        st_next.prev_level           = 1'b1;
        st_next.holding              = 1'b0;
        st_next.second_click_wait    = 1'b0;
        st_next.single_click_pending = 1'b0;
        res.exit_request             = 1'b1;
        done                         = 1'b1;
      end else if (held > TimeW'(cfg.hold_ms)) begin
        st_next.holding = 1'b1;
      end
    end

    if (!done && level && !eff_prev) begin
      if (held < TimeW'(cfg.hold_ms)) begin
        if (st.second_click_wait &&
            ((now - st.release_time) <= TimeW'(cfg.double_click_ms))) begin
          st_next.second_click_wait    = 1'b0;
          st_next.single_click_pending = 1'b0;
          st_next.prev_level           = 1'b1;
          res.exit_request             = 1'b1;
          done                         = 1'b1;
        end else begin
          st_next.second_click_wait    = 1'b1;
          st_next.release_time         = now;
          st_next.single_click_pending = 1'b1;
        end
      end
      if (!done) begin
        st_next.holding = 1'b0;
      end
    end

    if (!done) begin
      since_rel = now - st_next.release_time;
      if (st_next.single_click_pending && (since_rel > TimeW'(cfg.double_click_ms))) begin
        st_next.single_click_pending = 1'b0;
        st_next.mode                 = mode_t'(st.mode + 2'd1);
      end
      if (st_next.second_click_wait && (since_rel > TimeW'(cfg.double_click_ms))) begin
        st_next.second_click_wait = 1'b0;
      end
      st_next.prev_level = level;

      // step clamped to 1..4, tripled while holding
      if (cfg.base_step == '0) begin
        step = 4'd1;
      end else if (cfg.base_step > 3'd4) begin
        step = 4'd4;
      end else begin
        step = {1'b0, cfg.base_step};
      end
      if (st_next.holding) begin
        step = 4'(step * 4'd3);
      end

      if (since_scroll > TimeW'(cfg.scroll_period_ms)) begin
        st_next.scroll_time = now;
        off = (OffW+1)'(st.offset);
        if (st_next.mode == MODE_DOWN) begin
          off = off + signed'({13'd0, step});
        end else if (st_next.mode == MODE_UP) begin
          off = off - signed'({13'd0, step});
        end
        if (off > 0) begin
          off          = '0;
          st_next.mode = MODE_TOP;
        end
        if (off < (OffW+1)'(cfg.min_offset)) begin
          off          = (OffW+1)'(cfg.min_offset);
          st_next.mode = MODE_BOTTOM;
        end
        st_next.offset = off[OffW-1:0];
        res.redraw     = 1'b1;
      end
      res.scroll_offset = st_next.offset;
      res.scroll_mode   = st_next.mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.prev_level           <= 1'b1;
      st.press_time           <= '0;
      st.release_time         <= '0;
      st.scroll_time          <= '0;
      st.holding              <= 1'b0;
      st.second_click_wait    <= 1'b0;
      st.single_click_pending <= 1'b0;
      st.drain                <= 1'b0;
      st.mode                 <= MODE_TOP;
      st.offset               <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// testbench for the button gesture scroll control unit
//
// a directed table walks reset values, double click and long-press exits,
// the press drain, timestamp wrap, step limits, positive and lowest bounds
// and zero thresholds; random gesture streams then run under several
// register settings. every sample gets one predicted view, compared field
// by field in order; both channels idle at random and the result side is
// once held off long enough to back the block up
// ---------------------------------------------------------------------------
module tb_top;
  import bgsc_pkg::*;

  localparam int unsigned HalfPeriod  = 4;
  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned PipeLatency = 2;
  localparam int unsigned PhaseCount  = 8;
  localparam int unsigned PhaseItems  = 220;
  localparam int unsigned LongStall   = 300;
  localparam int unsigned MaxPrints   = 100;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic               level;
    logic [TimeW-1:0]   stamp;
    logic [CfgIdxW-1:0] reg_index;
    logic [CfgW-1:0]    reg_data;
    bit                 typed;
    res_t               view;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_wdata;

  bgsc_in_if  smp();
  bgsc_out_if res();

  button_gesture_scroll_control_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .samples   (smp),
    .results   (res)
  );

  always #(HalfPeriod) clk = ~clk;

  // register shadow
  logic [MsW-1:0]         s_long, s_hold, s_double, s_period;
  logic [StepW-1:0]       s_step;
  logic signed [OffW-1:0] s_min;

  // gesture and scroll state
  logic                   g_prev;
  logic [TimeW-1:0]       g_press_at, g_release_at, g_scroll_at;
  logic                   g_holding, g_second_wait, g_click_pending, g_draining;
  mode_t                  g_mode;
  logic signed [OffW-1:0] g_offset;

  res_t        expected_views[$];
  plan_row_t   plan[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          cycles = 0;
  int          items_sent = 0;
  int unsigned tick_max = 1;
  logic [TimeW-1:0] now_stamp;
  bit          src_quiet = 1'b0;
  bit          snk_quiet = 1'b0;
  bit          stall_req = 1'b0;

  task automatic predict_view(input logic level, input logic [TimeW-1:0] now,
                              output res_t view);
    logic [TimeW-1:0] held, since_rel;
    int               step, off;
    bit               done;
    view.exit_request = 1'b0;
    view.redraw = 1'b0;
    done = 1'b0;
    if (g_draining) begin
      if (!level) begin
        done = 1'b1;
      end else begin
        g_draining = 1'b0;
        g_prev = 1'b1;
      end
    end
    if (!done && !level && g_prev) begin
      g_press_at = now;
      g_holding = 1'b0;
    end
    if (!done && !level && !g_prev) begin
      held = now - g_press_at;
      if (held > s_long && (g_mode == MODE_TOP || g_mode == MODE_BOTTOM)) begin
        g_draining = 1'b1;
        g_prev = 1'b1;
        g_holding = 1'b0;
        g_second_wait = 1'b0;
        g_click_pending = 1'b0;
        view.exit_request = 1'b1;
        done = 1'b1;
      end else if (held > s_hold) begin
        g_holding = 1'b1;
      end
    end
    if (!done && level && !g_prev) begin
      if (now - g_press_at < s_hold) begin
        if (g_second_wait && (now - g_release_at) <= s_double) begin
          g_second_wait = 1'b0;
          g_click_pending = 1'b0;
          g_prev = 1'b1;
          view.exit_request = 1'b1;
          done = 1'b1;
        end else begin
          g_second_wait = 1'b1;
          g_release_at = now;
          g_click_pending = 1'b1;
        end
      end
      if (!done) g_holding = 1'b0;
    end
    if (!done) begin
      since_rel = now - g_release_at;
      if (g_click_pending && since_rel > s_double) begin
        g_click_pending = 1'b0;
        g_mode = mode_t'(g_mode + 2'd1);
      end
      if (g_second_wait && since_rel > s_double) g_second_wait = 1'b0;
      g_prev = level;
      if (s_step == 0) step = 1;
      else if (s_step > 4) step = 4;
      else step = int'(s_step);
      if (g_holding) step = step * 3;
      if (now - g_scroll_at > s_period) begin
        g_scroll_at = now;
        off = int'(g_offset);
        if (g_mode == MODE_DOWN) off = off + step;
        else if (g_mode == MODE_UP) off = off - step;
        if (off > 0) begin
          off = 0;
          g_mode = MODE_TOP;
        end
        if (off < s_min) begin
          off = int'(s_min);
          g_mode = MODE_BOTTOM;
        end
        g_offset = off[OffW-1:0];
        view.redraw = 1'b1;
      end
    end
    view.scroll_offset = g_offset;
    view.scroll_mode = g_mode;
  endtask

  function automatic int idle_len(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TimeW-1:0] tick();
    if ($urandom_range(0, 99) == 0) return $urandom;
    return $urandom_range(0, tick_max);
  endfunction

  function automatic void plan_sample(logic level, logic [TimeW-1:0] stamp);
    plan_row_t row;
    row.kind = ROW_SAMPLE;
    row.level = level;
    row.stamp = stamp;
    row.reg_index = '0;
    row.reg_data = '0;
    row.typed = 1'b0;
    row.view = '0;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void plan_view(logic level, logic [TimeW-1:0] stamp, logic ex,
                                    logic rd, logic signed [OffW-1:0] off, mode_t md);
    plan_row_t row;
    row.kind = ROW_SAMPLE;
    row.level = level;
    row.stamp = stamp;
    row.reg_index = '0;
    row.reg_data = '0;
    row.typed = 1'b1;
    row.view.exit_request = ex;
    row.view.redraw = rd;
    row.view.scroll_offset = off;
    row.view.scroll_mode = md;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void plan_write(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    plan_row_t row;
    row.kind = ROW_WRITE;
    row.level = 1'b1;
    row.stamp = '0;
    row.reg_index = idx;
    row.reg_data = data;
    row.typed = 1'b0;
    row.view = '0;
    plan.insert(plan.size(), row);
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want_v);
    mismatches++;
    if (mismatches <= MaxPrints)
      $display("%0t: result %0d %s got %0d expected %0d",
               $time, results_seen, field, got, want_v);
  endtask

  // called just after a falling edge, returns just after a falling edge
  task automatic send_sample(input logic level, input logic [TimeW-1:0] stamp,
                             input bit typed, input res_t typed_view);
    int   gap;
    res_t view;
    gap = idle_len(src_quiet);
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    smp.valid <= 1'b1;
    smp.button_level <= level;
    smp.now_ms <= stamp;
    do @(posedge clk); while (smp.ready !== 1'b1);
    predict_view(level, stamp, view);
    expected_views.insert(expected_views.size(), typed ? typed_view : view);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LONG_PRESS:   s_long = data;
      CFG_HOLD:         s_hold = data;
      CFG_DOUBLE_CLICK: s_double = data;
      CFG_SCROLL_PER:   s_period = data;
      CFG_BASE_STEP:    s_step = data[StepW-1:0];
      CFG_MIN_OFFSET:   s_min = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_results_idle();
    smp.valid <= 1'b0;
    while (expected_views.size() != 0) @(negedge clk);
    repeat (2 * PipeLatency) @(negedge clk);
  endtask

  task automatic choose_settings(input int phase);
    logic [MsW-1:0]   lp, hd, dc, sp;
    logic [StepW-1:0] st;
    logic [CfgW-1:0]  mn;
    case (phase)
      0: begin
        lp = RST_LONG_PRESS;
        hd = RST_HOLD;
        dc = RST_DOUBLE_CLICK;
        sp = RST_SCROLL_PER;
        st = RST_BASE_STEP;
        mn = 16'hFF6A;
      end
      1: begin
        lp = '1;
        hd = '1;
        dc = '1;
        sp = '1;
        st = '1;
        mn = 16'h8000;
      end
      2: begin
        lp = '0;
        hd = '0;
        dc = '0;
        sp = '0;
        st = '0;
        mn = '0;
      end
      default: begin
        lp = MsW'($urandom_range(200, 1500));
        hd = MsW'($urandom_range(60, 700));
        dc = MsW'($urandom_range(40, 450));
        sp = MsW'($urandom_range(0, 120));
        st = StepW'($urandom_range(0, 7));
        case ($urandom_range(0, 7))
          0: mn = 16'h8000;
          1: mn = CfgW'($urandom_range(1, 16'h7FFF));
          2: mn = '0;
          default: mn = 16'h0000 - 16'($urandom_range(0, 400));
        endcase
      end
    endcase
    tick_max = 1 + (hd + dc) / 12;
    write_reg(CFG_LONG_PRESS, lp);
    write_reg(CFG_HOLD, hd);
    write_reg(CFG_DOUBLE_CLICK, dc);
    write_reg(CFG_SCROLL_PER, sp);
    write_reg(CFG_BASE_STEP, CfgW'(st));
    write_reg(CFG_MIN_OFFSET, mn);
  endtask

  // keep the button at one level for at least dur ms
  task automatic hold_level(input logic level, input logic [TimeW-1:0] dur);
    logic [TimeW-1:0] start;
    start = now_stamp;
    do begin
      now_stamp = now_stamp + tick();
      send_sample(level, now_stamp, 1'b0, '0);
    end while (now_stamp - start < dur);
  endtask

  function automatic logic [TimeW-1:0] short_press();
    if (s_hold == 0) return $urandom_range(0, 2);
    return $urandom_range(0, s_hold - 1);
  endfunction

  function automatic logic [TimeW-1:0] release_gap();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, s_double);
    return s_double + 1 + $urandom_range(0, s_double + s_period);
  endfunction

  task automatic run_gesture();
    int r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) src_quiet = !src_quiet;
    if (r < 30) begin
      hold_level(1'b0, short_press());
      hold_level(1'b1, release_gap());
    end else if (r < 50) begin
      hold_level(1'b0, short_press());
      hold_level(1'b1, $urandom_range(0, s_double));
      hold_level(1'b0, short_press());
      hold_level(1'b1, release_gap());
    end else if (r < 72) begin
      hold_level(1'b0, $urandom_range(s_hold, s_long + s_long / 2 + 2));
      hold_level(1'b1, release_gap());
    end else if (r < 82) begin
      hold_level(1'b1, release_gap());
    end else begin
      repeat ($urandom_range(1, 8)) begin
        now_stamp = now_stamp + tick();
        send_sample(1'($urandom_range(0, 1)), now_stamp, 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1) begin
      results_seen++;
      if (expected_views.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = expected_views.pop_front();
        if (res.exit_request !== want.exit_request)
          report_mismatch("exit_request", res.exit_request, want.exit_request);
        if (res.redraw !== want.redraw)
          report_mismatch("redraw", res.redraw, want.redraw);
        if (res.scroll_offset !== want.scroll_offset)
          report_mismatch("scroll_offset", res.scroll_offset, want.scroll_offset);
        if (res.scroll_mode !== want.scroll_mode)
          report_mismatch("scroll_mode", res.scroll_mode, want.scroll_mode);
      end
    end
  end

  initial begin : result_sink
    int stall_left;
    int held;
    res.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 149) == 0) snk_quiet = !snk_quiet;
      if (stall_req) begin
        stall_req = 1'b0;
        res.ready <= 1'b0;
        held = 0;
        while (held < LongStall) begin
          @(negedge clk);
          held++;
        end
      end else if (stall_left > 0) begin
        res.ready <= 1'b0;
        stall_left--;
      end else begin
        res.ready <= 1'b1;
        stall_left = idle_len(snk_quiet);
      end
    end
  end

  initial begin : stimulus
    int quota;
    int pause_at;
    int w;
    bit paused;
    smp.valid = 1'b0;
    smp.button_level = 1'b1;
    smp.now_ms = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    s_long = RST_LONG_PRESS;
    s_hold = RST_HOLD;
    s_double = RST_DOUBLE_CLICK;
    s_period = RST_SCROLL_PER;
    s_step = RST_BASE_STEP;
    s_min = '0;
    g_prev = 1'b1;
    g_press_at = '0;
    g_release_at = '0;
    g_scroll_at = '0;
    g_holding = 1'b0;
    g_second_wait = 1'b0;
    g_click_pending = 1'b0;
    g_draining = 1'b0;
    g_mode = MODE_TOP;
    g_offset = '0;
    paused = 1'b0;

    // reset values, double click, long press at top and its drain
    plan_view(1'b1, 32'd0, 1'b0, 1'b0, 16'sd0, MODE_TOP);
    plan_view(1'b1, 32'd81, 1'b0, 1'b1, 16'sd0, MODE_TOP);
    plan_sample(1'b0, 32'd100);
    plan_sample(1'b1, 32'd150);
    plan_sample(1'b0, 32'd200);
    plan_view(1'b1, 32'd250, 1'b1, 1'b0, 16'sd0, MODE_TOP);
    plan_sample(1'b0, 32'd1000);
    plan_view(1'b0, 32'd2001, 1'b1, 1'b0, 16'sd0, MODE_TOP);
    plan_view(1'b0, 32'd5000, 1'b0, 1'b0, 16'sd0, MODE_TOP);
    plan_sample(1'b1, 32'd5001);
    // single click to scroll up, then a hold that triples the step
    plan_write(CFG_MIN_OFFSET, 16'h8000);
    plan_write(CFG_BASE_STEP, 16'd4);
    plan_sample(1'b0, 32'd6000);
    plan_sample(1'b1, 32'd6100);
    plan_sample(1'b1, 32'd6401);
    plan_sample(1'b0, 32'd6500);
    plan_sample(1'b0, 32'd7000);
    plan_sample(1'b0, 32'd9000);
    plan_sample(1'b1, 32'd9100);
    // timestamp wrap
    plan_sample(1'b1, 32'hFFFF_FFFF);
    plan_sample(1'b0, 32'h0000_0000);
    plan_sample(1'b1, 32'h0000_0010);
    // step below and above its range
    plan_write(CFG_BASE_STEP, 16'd0);
    plan_sample(1'b1, 32'h0000_1000);
    plan_write(CFG_BASE_STEP, 16'd7);
    plan_sample(1'b1, 32'h0000_2000);
    // positive lower bound pins the view at the bottom
    plan_write(CFG_MIN_OFFSET, 16'h7FFF);
    plan_view(1'b1, 32'h0000_3000, 1'b0, 1'b1, 16'sh7FFF, MODE_BOTTOM);
    // zero thresholds and period
    plan_write(CFG_LONG_PRESS, 16'd0);
    plan_write(CFG_HOLD, 16'd0);
    plan_write(CFG_DOUBLE_CLICK, 16'd0);
    plan_write(CFG_SCROLL_PER, 16'd0);
    plan_write(CFG_MIN_OFFSET, 16'h8000);
    plan_sample(1'b0, 32'h0000_3000);
    plan_view(1'b0, 32'h0000_3001, 1'b1, 1'b0, 16'sh7FFF, MODE_BOTTOM);
    plan_view(1'b0, 32'h0000_3005, 1'b0, 1'b0, 16'sh7FFF, MODE_BOTTOM);
    plan_sample(1'b1, 32'h0000_3006);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_results_idle();
        write_reg(plan[i].reg_index, plan[i].reg_data);
      end else begin
        send_sample(plan[i].level, plan[i].stamp, plan[i].typed, plan[i].view);
      end
    end

    now_stamp = $urandom;
    for (int phase = 0; phase < PhaseCount; phase++) begin
      wait_results_idle();
      choose_settings(phase);
      quota = items_sent + PhaseItems;
      pause_at = items_sent + PhaseItems / 2;
      // receiver holds off while samples keep coming
      if (phase == 3) stall_req = 1'b1;
      while (items_sent < quota) begin
        if (phase == 5 && !paused && items_sent >= pause_at) begin
          wait_results_idle();
          paused = 1'b1;
        end
        run_gesture();
      end
    end

    smp.valid <= 1'b0;
    for (w = 0; w < 4000 && expected_views.size() != 0; w++) @(negedge clk);
    repeat (2 * PipeLatency + 4) @(negedge clk);
    if (expected_views.size() != 0)
      report_mismatch("items never returned", expected_views.size(), 0);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
